// ===== src/hoeffding_prefix_interval_unit_defines.svh =====
`ifndef HOEFFDING_PREFIX_INTERVAL_UNIT_DEFINES_SVH
`define HOEFFDING_PREFIX_INTERVAL_UNIT_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define HPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define HPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hpi_pkg.sv =====
package hpi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_SAMPLES = 65536;
    localparam int VAL_W       = FRAC_BITS + 1;
    localparam int LOG_W       = FRAC_BITS + 8;
    localparam int SUM_W       = 33;
    localparam int CNT_W       = 17;
    localparam int DIV_W       = LOG_W + FRAC_BITS;
    localparam int DVS_W       = CNT_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int ROOT_W      = DIV_W / 2;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);

    typedef logic [VAL_W-1:0]      t_val;
    typedef logic [LOG_W-1:0]      t_log;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DIV_W-1:0]      t_div;
    typedef logic [DVS_W-1:0]      t_dvs;
    typedef logic [DIV_CNT_W-1:0]  t_div_cnt;
    typedef logic [ROOT_W-1:0]     t_root;
    typedef logic [SQRT_CNT_W-1:0] t_sqrt_cnt;

    localparam t_val      ONE_Q     = t_val'(1) << FRAC_BITS;
    localparam t_cnt      MAX_CNT   = t_cnt'(MAX_SAMPLES);
    localparam t_log      LOG_RESET = t_log'(45426);
    localparam t_div_cnt  DIV_LAST  = t_div_cnt'(DIV_W - 1);
    localparam t_sqrt_cnt SQRT_LAST = t_sqrt_cnt'(ROOT_W - 1);

    typedef struct packed {
        t_val sample;
        logic restart;
    } t_in_req;

    typedef struct packed {
        t_val prefix_mean;
        t_val lower_bound;
        t_val upper_bound;
        logic saturated;
    } t_out_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_HOLD
    } t_state;

endpackage

// ===== src/hpi_div.sv =====
module hpi_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hpi_pkg::t_div i_dividend,
    input  hpi_pkg::t_dvs i_divisor,
    output logic          o_done,
    output hpi_pkg::t_div o_quotient
);

    logic              r_busy;
    logic              r_done;
    hpi_pkg::t_div_cnt r_cnt;
    hpi_pkg::t_dvs     r_rem;
    hpi_pkg::t_dvs     n_rem;
    hpi_pkg::t_dvs     r_dvs;
    hpi_pkg::t_div     r_quo;
    hpi_pkg::t_div     n_quo;
    logic [hpi_pkg::DVS_W:0] rem_sh;
    logic [hpi_pkg::DVS_W:0] dvs_ext;
    logic              ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[hpi_pkg::DIV_W-1]};
        dvs_ext = {1'b0, r_dvs};
        ge      = rem_sh >= dvs_ext;
        n_rem   = ge ? hpi_pkg::t_dvs'(rem_sh - dvs_ext) : hpi_pkg::t_dvs'(rem_sh);
        n_quo   = {r_quo[hpi_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hpi_pkg::DIV_LAST;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/hpi_sqrt.sv =====
module hpi_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hpi_pkg::t_div  i_value,
    output logic           o_done,
    output hpi_pkg::t_root o_root
);

    logic               r_busy;
    logic               r_done;
    hpi_pkg::t_sqrt_cnt r_cnt;
    hpi_pkg::t_div      r_val;
    hpi_pkg::t_root     r_root;
    hpi_pkg::t_root     n_root;
    logic [hpi_pkg::ROOT_W:0]   r_rem;
    logic [hpi_pkg::ROOT_W:0]   n_rem;
    logic [hpi_pkg::ROOT_W+2:0] rem_sh;
    logic [hpi_pkg::ROOT_W+2:0] trial;
    logic               ge;

    always_comb begin
        rem_sh = {r_rem, r_val[hpi_pkg::DIV_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = rem_sh >= trial;
        n_rem  = ge ? (hpi_pkg::ROOT_W+1)'(rem_sh - trial) : (hpi_pkg::ROOT_W+1)'(rem_sh);
        n_root = {r_root[hpi_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hpi_pkg::SQRT_LAST;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[hpi_pkg::DIV_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== src/hoeffding_prefix_interval_unit.sv =====
// Running mean with a Hoeffding confidence interval. Each request carries one
// Q1.16 sample (values above 1.0 count as 1.0) and a restart flag that clears
// the sum and count first; each request yields one response with the prefix
// mean, the interval mean -/+ sqrt(L/(2n)) clamped to [0,1], and a saturated
// flag set when the count already stood at 65536 and the sample was dropped.
// L is the 24-bit Q8.16 register written through i_cfg_we/i_cfg_wdata (reset
// about ln 2); write it only while no request is in flight. Once a request is
// accepted, two bit-serial restoring dividers run side by side (mean and
// L*2^16/(2n)), then a bit-serial square root runs, and the response enters
// the output register; while i_out_stall holds the previous response there,
// the new one waits in ST_HOLD. The next request can be accepted the cycle after
// the response is loaded, so no request is taken while another is in flight.
`include "hoeffding_prefix_interval_unit_defines.svh"

module hoeffding_prefix_interval_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hpi_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hpi_pkg::t_out_rsp o_out_data,
    input  logic              i_cfg_we,
    input  hpi_pkg::t_log     i_cfg_wdata
);

    hpi_pkg::t_state   r_state;
    hpi_pkg::t_state   n_state;
    hpi_pkg::t_log     r_log;
    hpi_pkg::t_sum     r_sum;
    hpi_pkg::t_sum     n_sum;
    hpi_pkg::t_cnt     r_cnt;
    hpi_pkg::t_cnt     n_cnt;
    logic              r_sat;
    hpi_pkg::t_val     r_mean;
    hpi_pkg::t_out_rsp r_out;
    logic              r_out_valid;

    logic              in_acc;
    logic              out_free;
    logic              load;
    hpi_pkg::t_val     s_clamp;
    hpi_pkg::t_sum     base_sum;
    hpi_pkg::t_cnt     base_cnt;
    logic              acc_sat;

    logic              w_mean_done;
    logic              w_q_done;
    logic              w_sqrt_done;
    hpi_pkg::t_div     w_mean_quo;
    hpi_pkg::t_div     w_q_quo;
    hpi_pkg::t_root    w_root;

    hpi_pkg::t_root    mean_ext;
    hpi_pkg::t_val     lo;
    hpi_pkg::t_val     hi;
    logic [hpi_pkg::ROOT_W:0] hi_sum;
    hpi_pkg::t_out_rsp rsp;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        in_acc   = i_in_valid && (r_state == hpi_pkg::ST_IDLE);
        s_clamp  = (i_in_data.sample > hpi_pkg::ONE_Q) ? hpi_pkg::ONE_Q : i_in_data.sample;
        base_sum = i_in_data.restart ? '0 : r_sum;
        base_cnt = i_in_data.restart ? '0 : r_cnt;
        acc_sat  = base_cnt >= hpi_pkg::MAX_CNT;
        n_sum    = acc_sat ? base_sum : base_sum + hpi_pkg::t_sum'(s_clamp);
        n_cnt    = acc_sat ? base_cnt : base_cnt + hpi_pkg::t_cnt'(1);
    end

    hpi_div u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (hpi_pkg::t_div'(n_sum)),
        .i_divisor  (hpi_pkg::t_dvs'(n_cnt)),
        .o_done     (w_mean_done),
        .o_quotient (w_mean_quo)
    );

    hpi_div u_div_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (hpi_pkg::t_div'(r_log) << hpi_pkg::FRAC_BITS),
        .i_divisor  ({n_cnt, 1'b0}),
        .o_done     (w_q_done),
        .o_quotient (w_q_quo)
    );

    hpi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_q_done),
        .i_value (w_q_quo),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_comb begin
        mean_ext = hpi_pkg::t_root'(r_mean);
        lo       = (mean_ext > w_root) ? hpi_pkg::t_val'(mean_ext - w_root) : '0;
        hi_sum   = {1'b0, mean_ext} + {1'b0, w_root};
        hi       = (hi_sum > (hpi_pkg::ROOT_W+1)'(hpi_pkg::ONE_Q)) ? hpi_pkg::ONE_Q
                                                                   : hpi_pkg::t_val'(hi_sum);
        rsp.prefix_mean = r_mean;
        rsp.lower_bound = lo;
        rsp.upper_bound = hi;
        rsp.saturated   = r_sat;
    end

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        unique case (r_state)
            hpi_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = hpi_pkg::ST_DIV;
                end
            end
            hpi_pkg::ST_DIV: begin
                if (w_q_done) begin
                    n_state = hpi_pkg::ST_SQRT;
                end
            end
            hpi_pkg::ST_SQRT: begin
                if (w_sqrt_done) begin
                    load    = out_free;
                    n_state = out_free ? hpi_pkg::ST_IDLE : hpi_pkg::ST_HOLD;
                end
            end
            hpi_pkg::ST_HOLD: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = hpi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hpi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpi_pkg::ST_IDLE;
            r_log       <= hpi_pkg::LOG_RESET;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_log <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sat <= acc_sat;
        end
        if (w_mean_done) begin
            r_mean <= hpi_pkg::t_val'(w_mean_quo);
        end
        if (load) begin
            r_out <= rsp;
        end
    end

    assign o_in_stall  = (r_state != hpi_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `HPI_ASSERT_SAME(a_div_lockstep, w_mean_done || w_q_done, w_mean_done && w_q_done, "dividers out of step")
    `HPI_ASSERT_SAME(a_div_state, w_q_done, r_state == hpi_pkg::ST_DIV, "division finished outside ST_DIV")
    `HPI_ASSERT_SAME(a_sqrt_state, w_sqrt_done, r_state == hpi_pkg::ST_SQRT, "root finished outside ST_SQRT")
    `HPI_ASSERT_NEXT(a_count_range, in_acc, (r_cnt != '0) && (r_cnt <= hpi_pkg::MAX_CNT), "count out of range")
    `HPI_ASSERT_SAME(a_bound_order, r_out_valid, (r_out.lower_bound <= r_out.prefix_mean) && (r_out.prefix_mean <= r_out.upper_bound) && (r_out.upper_bound <= hpi_pkg::ONE_Q), "interval out of order")

endmodule
